### src/sfp_pkg.sv
package sfp_pkg;

   // Frame header bytes
   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;
   localparam logic [7:0] CHK_SEED    = 8'hFF;

   // Datapoint ids inside a report frame
   localparam logic [7:0] DP_TEMPERATURE = 8'd1;
   localparam logic [7:0] DP_HUMIDITY    = 8'd2;
   localparam logic [7:0] DP_IGNORED     = 8'd9;

   // Conversion constants: tenths C to tenths F is x*90/50 + 320
   localparam logic [31:0] TEMP_SCALE   = 32'd90;
   localparam logic [31:0] TEMP_BIAS    = 32'd320;
   localparam logic [31:0] HUMID_SCALE  = 32'd10;
   // Floor divide by 50: halve, then multiply by ceil(2^36/25) and drop 36 bits
   localparam logic [31:0] RECIP_25     = 32'd2748779070;
   localparam int          RECIP_SHIFT  = 36;

   localparam logic [7:0] REPORT_CMD_RESET = 8'd7;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC    = 3'd1,
      PH_VERSION = 3'd2,
      PH_COMMAND = 3'd3,
      PH_LEN_HI  = 3'd4,
      PH_LEN_LO  = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NONE        = 3'd0,
      KIND_TEMPERATURE = 3'd1,
      KIND_HUMIDITY    = 3'd2,
      KIND_IGNORED     = 3'd3,
      KIND_UNKNOWN     = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_FAHRENHEIT   = 2'd0,
      CSR_TEMP_OFFSET  = 2'd1,
      CSR_HUMID_OFFSET = 2'd2,
      CSR_REPORT_CODE  = 2'd3
   } csr_index_type;

   // One finished frame
   typedef struct packed {
      logic        good;
      logic [7:0]  command;
      logic [7:0]  version;
      logic [15:0] length;
      logic [7:0]  first;
      logic [7:0]  second;
      kind_type    kind;
      logic [31:0] value;
   } frame_rec_type;

   // Frame plus scaled values on the way to the result register
   typedef struct packed {
      frame_rec_type frame;
      logic [31:0]   scaled;
      logic [31:0]   humid;
   } conv_rec_type;

endpackage

### src/sfp_parser.sv
module sfp_parser #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [7:0]            req_rx_byte,
   output logic                  req_stall,
   input  logic [7:0]            report_code,
   output logic                  rec_valid,
   output sfp_pkg::frame_rec_type rec,
   input  logic                  rec_ready
);
   import sfp_pkg::*;

   localparam int              IW        = $clog2(BUFFER_DEPTH);
   localparam logic [IW-1:0]   LAST_IDX  = IW'(BUFFER_DEPTH - 1);
   localparam logic [15:0]     DEPTH_LEN = 16'(BUFFER_DEPTH);

   phase_type     phase_ff, phase_in;
   logic [7:0]    version_ff, version_in;
   logic [7:0]    command_ff, command_in;
   logic [15:0]   length_ff, length_in;
   logic [IW-1:0] index_ff, index_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    first_ff, first_in;
   logic [7:0]    second_ff, second_in;
   logic [31:0]   value_ff, value_in;
   logic          rec_valid_ff, rec_valid_in;
   frame_rec_type rec_ff, rec_in;

   logic take;
   logic in_payload;
   logic frame_end;
   logic fits;
   logic good;
   kind_type kind;

   // Hold input while a finished frame cannot move on
   assign req_stall  = rec_valid_ff && !rec_ready;
   assign take       = req_valid && !req_stall;
   assign in_payload = (phase_ff == PH_PAYLOAD);
   assign frame_end  = in_payload && ((16'(index_ff) >= length_ff) || (index_ff == LAST_IDX));
   assign fits       = length_ff < DEPTH_LEN;
   assign good       = fits && (sum_ff == req_rx_byte);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HUNT: begin
            if (take && req_rx_byte == SYNC_FIRST) phase_in = PH_SYNC;
            else if (take && req_rx_byte == SYNC_SECOND) phase_in = PH_VERSION;
         end
         PH_SYNC: begin
            if (take && req_rx_byte == SYNC_SECOND) phase_in = PH_VERSION;
         end
         PH_VERSION: begin
            if (take) phase_in = PH_COMMAND;
         end
         PH_COMMAND: begin
            if (take) phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            if (take) phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            if (take) phase_in = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (take && frame_end) phase_in = PH_HUNT;
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   // Capture the payload entries that the result reports
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      value_in  = value_ff;
      if (take && in_payload) begin
         case (index_ff)
            IW'(0): first_in = req_rx_byte;
            IW'(1): second_in = req_rx_byte;
            IW'(4): value_in[31:24] = req_rx_byte;
            IW'(5): value_in[23:16] = req_rx_byte;
            IW'(6): value_in[15:8] = req_rx_byte;
            IW'(7): value_in[7:0] = req_rx_byte;
            default: ;
         endcase
      end
   end

   // Classify a good report frame by its datapoint id
   always_comb begin
      kind = KIND_NONE;
      if (good && command_ff == report_code) begin
         case (first_in)
            DP_TEMPERATURE: kind = KIND_TEMPERATURE;
            DP_HUMIDITY:    kind = KIND_HUMIDITY;
            DP_IGNORED:     kind = KIND_IGNORED;
            default:        kind = KIND_UNKNOWN;
         endcase
      end
   end

   // Header fields, running checksum and frame record
   always_comb begin
      version_in   = version_ff;
      command_in   = command_ff;
      length_in    = length_ff;
      index_in     = index_ff;
      sum_in       = sum_ff;
      rec_valid_in = rec_valid_ff && !rec_ready;
      rec_in       = rec_ff;
      if (take) begin
         unique case (phase_ff)
            PH_VERSION: version_in = req_rx_byte;
            PH_COMMAND: command_in = req_rx_byte;
            PH_LEN_HI:  length_in = {req_rx_byte, 8'h00};
            PH_LEN_LO: begin
               length_in = {length_ff[15:8], req_rx_byte};
               index_in  = '0;
               sum_in    = CHK_SEED + req_rx_byte + version_ff + command_ff;
            end
            PH_PAYLOAD: begin
               sum_in = sum_ff + req_rx_byte;
               if (frame_end) begin
                  index_in       = '0;
                  rec_valid_in   = 1'b1;
                  rec_in.good    = good;
                  rec_in.command = command_ff;
                  rec_in.version = version_ff;
                  rec_in.length  = length_ff;
                  rec_in.first   = first_in;
                  rec_in.second  = second_in;
                  rec_in.kind    = kind;
                  rec_in.value   = value_in;
               end else begin
                  index_in = index_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         index_ff     <= '0;
         first_ff     <= '0;
         second_ff    <= '0;
         value_ff     <= '0;
         rec_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         index_ff     <= index_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         value_ff     <= value_in;
         rec_valid_ff <= rec_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      version_ff <= version_in;
      command_ff <= command_in;
      length_ff  <= length_in;
      sum_ff     <= sum_in;
      rec_ff     <= rec_in;
   end

   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

endmodule

### src/sfp_convert.sv
module sfp_convert (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  sfp_pkg::frame_rec_type in_rec,
   output logic                   in_ready,
   output logic                   out_valid,
   output sfp_pkg::conv_rec_type  out_rec,
   input  logic                   out_ready
);
   import sfp_pkg::*;

   logic         scale_valid_ff, scale_valid_in;
   conv_rec_type scale_ff, scale_in;
   logic         div_valid_ff, div_valid_in;
   conv_rec_type div_ff, div_in;
   logic         scale_ready;
   logic         div_ready;
   logic [62:0]  recip_prod;

   assign div_ready   = !div_valid_ff || out_ready;
   assign scale_ready = !scale_valid_ff || div_ready;
   assign in_ready    = scale_ready;

   // Scale stage: value*90 for Fahrenheit, value*10 for humidity
   always_comb begin
      scale_valid_in = scale_valid_ff && !div_ready;
      scale_in       = scale_ff;
      if (in_valid && scale_ready) begin
         scale_valid_in  = 1'b1;
         scale_in.frame  = in_rec;
         scale_in.scaled = in_rec.value * TEMP_SCALE;
         scale_in.humid  = in_rec.value * HUMID_SCALE;
      end
   end

   // Divide stage: floor(x/50) as floor((x>>1)/25) by reciprocal
   assign recip_prod = 63'(scale_ff.scaled[31:1]) * 63'(RECIP_25);

   always_comb begin
      div_valid_in = div_valid_ff && !out_ready;
      div_in       = div_ff;
      if (scale_valid_ff && div_ready) begin
         div_valid_in  = 1'b1;
         div_in        = scale_ff;
         div_in.scaled = 32'(recip_prod[62:RECIP_SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_valid_ff <= 1'b0;
         div_valid_ff   <= 1'b0;
      end else begin
         scale_valid_ff <= scale_valid_in;
         div_valid_ff   <= div_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scale_ff <= scale_in;
      div_ff   <= div_in;
   end

   assign out_valid = div_valid_ff;
   assign out_rec   = div_ff;

endmodule

### src/sensor_frame_parser_unit.sv
// Serial frame receiver for a temperature / humidity sensor module.
// Request channel: one received byte per request (req_valid, req_rx_byte,
// req_stall). The block hunts for the 0x55 0xAA header, reads version,
// command and a 16-bit length, collects the payload and checks the 8-bit
// additive checksum. A frame whose length reaches BUFFER_DEPTH ends after
// BUFFER_DEPTH payload bytes and is reported as bad.
// Response channel: one response per finished frame (rsp_valid ... rsp_stall)
// carrying the header, payload bytes 0 and 1, the reading kind and the
// stored temperature and humidity after this frame's update.
// Throughput: one byte per cycle while req_stall is low. A response passes
// from the byte that ends the frame through the frame register, the x90/x10
// scale stage, the reciprocal divide stage and the response register.
// A stalled response holds; bytes keep flowing until the three internal
// frame stages are full, then req_stall rises.
// Reset (synchronous) returns the parser to header hunting, clears the
// stored readings and payload entries and loads the register defaults.
// csr_*: write fahrenheit mode, offsets and report command while idle.
module sensor_frame_parser_unit #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [7:0]  req_rx_byte,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_checksum_good,
   output logic [7:0]  rsp_frame_command,
   output logic [7:0]  rsp_frame_version,
   output logic [15:0] rsp_payload_length,
   output logic [7:0]  rsp_payload_first,
   output logic [7:0]  rsp_payload_second,
   output logic [2:0]  rsp_reading_kind,
   output logic [31:0] rsp_temperature_value,
   output logic [31:0] rsp_humidity_value,
   output logic        rsp_value_changed,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import sfp_pkg::*;

   logic          fahrenheit_ff;
   logic [7:0]    temp_offset_ff;
   logic [7:0]    humid_offset_ff;
   logic [7:0]    report_code_ff;

   logic          frame_valid;
   frame_rec_type frame_rec;
   logic          frame_ready;
   logic          conv_valid;
   conv_rec_type  conv_rec;
   logic          conv_ready;

   logic          rsp_valid_ff, rsp_valid_in;
   frame_rec_type rsp_ff, rsp_in;
   logic          changed_ff, changed_in;
   logic [31:0]   temp_ff, temp_in;
   logic [31:0]   humid_ff, humid_in;
   logic [31:0]   temp_calc;
   logic [31:0]   humid_calc;
   logic          load;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fahrenheit_ff   <= 1'b0;
         temp_offset_ff  <= '0;
         humid_offset_ff <= '0;
         report_code_ff  <= REPORT_CMD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FAHRENHEIT:   fahrenheit_ff <= csr_data[0];
            CSR_TEMP_OFFSET:  temp_offset_ff <= csr_data;
            CSR_HUMID_OFFSET: humid_offset_ff <= csr_data;
            CSR_REPORT_CODE:  report_code_ff <= csr_data;
            default: ;
         endcase
      end
   end

   sfp_parser #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .report_code (report_code_ff),
      .rec_valid   (frame_valid),
      .rec         (frame_rec),
      .rec_ready   (frame_ready)
   );

   sfp_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (frame_valid),
      .in_rec    (frame_rec),
      .in_ready  (frame_ready),
      .out_valid (conv_valid),
      .out_rec   (conv_rec),
      .out_ready (conv_ready)
   );

   // Final readings: conversion select plus sign-extended offsets
   assign temp_calc  = (fahrenheit_ff ? (conv_rec.scaled + TEMP_BIAS) : conv_rec.frame.value)
                       + {{24{temp_offset_ff[7]}}, temp_offset_ff};
   assign humid_calc = conv_rec.humid + {{24{humid_offset_ff[7]}}, humid_offset_ff};

   assign conv_ready = !rsp_valid_ff || !rsp_stall;
   assign load       = conv_valid && conv_ready;

   // Response register and stored readings advance together
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      changed_in   = changed_ff;
      temp_in      = temp_ff;
      humid_in     = humid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = conv_rec.frame;
         changed_in   = 1'b0;
         case (conv_rec.frame.kind)
            KIND_TEMPERATURE: begin
               changed_in = (temp_calc != temp_ff);
               temp_in    = temp_calc;
            end
            KIND_HUMIDITY: begin
               changed_in = (humid_calc != humid_ff);
               humid_in   = humid_calc;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         temp_ff      <= '0;
         humid_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         temp_ff      <= temp_in;
         humid_ff     <= humid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      changed_ff <= changed_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_checksum_good     = rsp_ff.good;
   assign rsp_frame_command     = rsp_ff.command;
   assign rsp_frame_version     = rsp_ff.version;
   assign rsp_payload_length    = rsp_ff.length;
   assign rsp_payload_first     = rsp_ff.first;
   assign rsp_payload_second    = rsp_ff.second;
   assign rsp_reading_kind      = rsp_ff.kind;
   assign rsp_temperature_value = temp_ff;
   assign rsp_humidity_value    = humid_ff;
   assign rsp_value_changed     = changed_ff;

endmodule

### src/sfp_checker.sv
module sfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_checksum_good,
   input logic [7:0]  rsp_frame_command,
   input logic [2:0]  rsp_reading_kind,
   input logic [31:0] rsp_temperature_value,
   input logic [31:0] rsp_humidity_value,
   input logic        rsp_value_changed
);
   import sfp_pkg::*;

   // Hold a stalled response
   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_frame_command)
         && $stable(rsp_temperature_value) && $stable(rsp_humidity_value))
      else $error("stalled response changed");

   // Drop readings of a bad frame
   ap_bad_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_checksum_good |-> rsp_reading_kind == KIND_NONE && !rsp_value_changed)
      else $error("bad frame carried a reading");

   // Advance temperature only with a temperature response that flags it
   ap_temp_update: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(rsp_temperature_value) |->
         rsp_valid && rsp_reading_kind == KIND_TEMPERATURE && rsp_value_changed)
      else $error("temperature changed without a temperature report");

   // Advance humidity only with a humidity response that flags it
   ap_humid_update: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(rsp_humidity_value) |->
         rsp_valid && rsp_reading_kind == KIND_HUMIDITY && rsp_value_changed)
      else $error("humidity changed without a humidity report");

endmodule

bind sensor_frame_parser_unit sfp_checker u_sfp_checker (.*);
